[src/asac_pkg.sv]
// ----------------------------------------------------------------------------
// Atlas shelf allocator cache package
// Shared constants, codes and types of the atlas shelf allocator cache.
// ----------------------------------------------------------------------------
`default_nettype none

package asac_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned PAD         = 2;
  localparam int unsigned ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DIM_W  = 15;
  localparam int unsigned POS_W  = 14;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    STAT_HIT        = 3'd0,
    STAT_PLACED     = 3'd1,
    STAT_ZERO_SIZE  = 3'd2,
    STAT_TOO_LARGE  = 3'd3,
    STAT_ATLAS_FULL = 3'd4,
    STAT_CACHE_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE,
    PK_WRAP,
    PK_PLACE
  } pk_op_t;

  typedef struct packed {
    logic             zero_size;
    logic             too_large;
    logic             no_fit;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } pk_res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } entry_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } result_t;

endpackage

`default_nettype wire

[src/atlas_shelf_allocator_cache.sv]
// ----------------------------------------------------------------------------
// Atlas shelf allocator cache
// Looks up an image key among stored placements and, on a miss, places the
// image in a shelf-packed atlas and records the new entry.
//
// Usage:
// The input stream carries one request per beat: key, width and height. The
// output stream returns exactly one result per request, with the outcome
// code in out_tuser and the placement in out_tdata.
// The configuration channel writes the atlas width (index 0) and height
// (index 1); it is ready whenever reset is released and should be used only
// while idle.
// A request is handled one at a time. The key search reads one stored entry
// per cycle through the single read port of the entry memory. A hit ends
// the search and goes to the output; a miss is refused for a full cache,
// a zero size or an image too large for the atlas, else placement is
// tried. in_tready rises in the same cycle as the result is presented.
// A new request may be accepted while the previous result still waits in
// the output register; its result is held back until that one is taken.
// Reset clears the entry count, the shelf cursor and the output valid flag,
// and sets both atlas dimensions to 4096. Entry memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module atlas_shelf_allocator_cache (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tdata: key[31:0], width[46:32], height[61:47]
  input  wire logic [63:0]                     in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: pos_x[13:0], pos_y[27:14], placed_width[42:28], placed_height[57:43]
  output logic [63:0]                          out_tdata,
  // tuser: status[2:0]
  output logic [2:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [asac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [asac_pkg::DIM_W-1:0]      cfg_data
);
  import asac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FIT,
    ST_EMIT
  } state_t;

  state_t           state_r;
  logic [KEY_W-1:0] key_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [CNT_W-1:0] idx_r;
  logic             cmp_vld_r;
  logic [CNT_W-1:0] count_r;
  result_t          res_r;
  result_t          out_r;
  logic             out_valid_r;
  logic [DIM_W-1:0] atlas_w_r, atlas_h_r;

  logic    in_acc;
  logic    issue;
  logic    hit;
  logic    wr_en;
  entry_t  wr_data;
  entry_t  rd_data;
  pk_op_t  pk_op;
  pk_res_t pk;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  assign hit   = (state_r == ST_SCAN) && cmp_vld_r && (rd_data.key == key_r);
  assign issue = (state_r == ST_SCAN) && (idx_r < count_r) && !hit;
  assign wr_en = (state_r == ST_FIT) && !pk.no_fit;

  assign wr_data.key    = key_r;
  assign wr_data.pos_x  = pk.pos_x;
  assign wr_data.pos_y  = pk.pos_y;
  assign wr_data.width  = w_r;
  assign wr_data.height = h_r;

  always_comb begin
    pk_op = PK_NONE;
    if (state_r == ST_CHECK && count_r != CNT_W'(MAX_ENTRIES)) begin
      pk_op = PK_WRAP;
    end else if (state_r == ST_FIT) begin
      pk_op = PK_PLACE;
    end
  end

  asac_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ENTRY_AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (idx_r[ENTRY_AW-1:0]),
    .rd_data (rd_data)
  );

  asac_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (pk_op),
    .img_w   (w_r),
    .img_h   (h_r),
    .atlas_w (atlas_w_r),
    .atlas_h (atlas_h_r),
    .res     (pk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      atlas_w_r   <= ATLAS_RESET;
      atlas_h_r   <= ATLAS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ATLAS_WIDTH) begin
          atlas_w_r <= cfg_data;
        end else if (cfg_index == CFG_ATLAS_HEIGHT) begin
          atlas_h_r <= cfg_data;
        end
      end

      if (out_valid_r && out_tready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (in_acc) begin
            key_r   <= in_tdata[31:0];
            w_r     <= in_tdata[46:32];
            h_r     <= in_tdata[61:47];
            idx_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_r <= issue;
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (hit) begin
            res_r.status <= STAT_HIT;
            res_r.pos_x  <= rd_data.pos_x;
            res_r.pos_y  <= rd_data.pos_y;
            res_r.width  <= rd_data.width;
            res_r.height <= rd_data.height;
            state_r      <= ST_EMIT;
          end else if (!issue && !cmp_vld_r) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_r.pos_x  <= '0;
          res_r.pos_y  <= '0;
          res_r.width  <= '0;
          res_r.height <= '0;
          if (count_r == CNT_W'(MAX_ENTRIES)) begin
            res_r.status <= STAT_CACHE_FULL;
            state_r      <= ST_EMIT;
          end else if (pk.zero_size) begin
            res_r.status <= STAT_ZERO_SIZE;
            state_r      <= ST_EMIT;
          end else if (pk.too_large) begin
            res_r.status <= STAT_TOO_LARGE;
            state_r      <= ST_EMIT;
          end else begin
            state_r <= ST_FIT;
          end
        end
        ST_FIT: begin
          if (pk.no_fit) begin
            res_r.status <= STAT_ATLAS_FULL;
          end else begin
            res_r.status <= STAT_PLACED;
            res_r.pos_x  <= pk.pos_x;
            res_r.pos_y  <= pk.pos_y;
            res_r.width  <= w_r;
            res_r.height <= h_r;
            count_r      <= count_r + 1'b1;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'b0, out_r.height, out_r.width, out_r.pos_y, out_r.pos_x};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds the cache size");

  a_write_counts : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("stored entry did not advance the entry count");

  a_hit_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (idx_r != '0) && (idx_r <= count_r))
    else $error("key match outside the stored entries");

  a_emit_result : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && (!out_valid_r || out_tready) |=> out_valid_r)
    else $error("finished request was not presented on the output");

endmodule

`default_nettype wire

[src/asac_store.sv]
// ----------------------------------------------------------------------------
// Atlas shelf allocator cache entry store
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_store (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [asac_pkg::ENTRY_AW-1:0] wr_addr,
  input  wire asac_pkg::entry_t              wr_data,
  input  wire logic                          rd_en,
  input  wire logic [asac_pkg::ENTRY_AW-1:0] rd_addr,
  output asac_pkg::entry_t                   rd_data
);
  import asac_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/asac_packer.sv]
// ----------------------------------------------------------------------------
// Atlas shelf allocator cache shelf packer
// Holds the shelf cursor and applies the wrap and placement steps.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_packer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire asac_pkg::pk_op_t           op,
  input  wire logic [asac_pkg::DIM_W-1:0] img_w,
  input  wire logic [asac_pkg::DIM_W-1:0] img_h,
  input  wire logic [asac_pkg::DIM_W-1:0] atlas_w,
  input  wire logic [asac_pkg::DIM_W-1:0] atlas_h,
  output asac_pkg::pk_res_t               res
);
  import asac_pkg::*;

  logic [DIM_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [15:0]      cursor_y_r, cursor_y_nxt;
  logic [DIM_W-1:0] shelf_h_r,  shelf_h_nxt;

  logic [15:0] pw, ph;
  logic [16:0] x_end, y_end, y_wrap;
  logic        need_wrap;

  assign pw        = 16'(img_w) + 16'(PAD);
  assign ph        = 16'(img_h) + 16'(PAD);
  assign x_end     = 17'(cursor_x_r) + 17'(pw);
  assign y_end     = 17'(cursor_y_r) + 17'(ph);
  assign y_wrap    = 17'(cursor_y_r) + 17'(shelf_h_r);
  assign need_wrap = x_end > 17'(atlas_w);

  assign res.zero_size = (img_w == '0) || (img_h == '0);
  assign res.too_large = (pw > 16'(atlas_w)) || (ph > 16'(atlas_h));
  assign res.no_fit    = y_end > 17'(atlas_h);
  assign res.pos_x     = cursor_x_r[POS_W-1:0];
  assign res.pos_y     = cursor_y_r[POS_W-1:0];

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    shelf_h_nxt  = shelf_h_r;
    unique case (op)
      PK_WRAP: begin
        if (!res.zero_size && !res.too_large && need_wrap) begin
          cursor_x_nxt = '0;
          cursor_y_nxt = y_wrap[16] ? 16'hFFFF : y_wrap[15:0];
          shelf_h_nxt  = '0;
        end
      end
      PK_PLACE: begin
        if (!res.no_fit) begin
          cursor_x_nxt = x_end[DIM_W-1:0];
          if (ph > 16'(shelf_h_r)) begin
            shelf_h_nxt = ph[DIM_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      shelf_h_r  <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      shelf_h_r  <= shelf_h_nxt;
    end
  end

endmodule

`default_nettype wire
